FILE: hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_COMBINE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int KEY_W = 32;
    localparam int OUT_TAG_W = 10;
    localparam int OUT_CNT_W = 10;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_ROOT,    // read root and last entry
        OP_POP_START,  // latch removed entry, place last at root
        OP_DN_READ,    // read both children of the cursor
        OP_DN_STEP,    // compare, swap or finish
        OP_PUSH_START, // write new entry at the end
        OP_UP_READ,    // read parent of the cursor
        OP_UP_STEP,    // compare, swap or finish
        OP_ROOT_READ,  // read root for the report
        OP_ROOT_LATCH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic use_sum;    // push the saturated sum instead of the input key
        logic second_pop; // the removed tag goes to the second slot
        logic clear_tags;
    } t_cmd;

    typedef struct packed {
        logic done;       // current sift has finished
        logic empty;
        logic lt_two;
        logic full;
    } t_stat;

endpackage

FILE: hw/rtl/mhpq_datapath.sv
module mhpq_datapath #(
    parameter int CAPACITY = 512,
    parameter int TAG_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [mhpq_pkg::KEY_W-1:0]             i_key,
    input  logic [TAG_BITS-1:0]                    i_tag,
    input  mhpq_pkg::t_cmd                         i_cmd,
    output mhpq_pkg::t_stat                        o_stat,
    output logic [TAG_BITS-1:0]                    o_first_tag,
    output logic [TAG_BITS-1:0]                    o_second_tag,
    output logic [mhpq_pkg::KEY_W-1:0]             o_min_key,
    output logic [TAG_BITS-1:0]                    o_min_tag,
    output logic [$clog2(CAPACITY+1)-1:0]          o_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int EW = mhpq_pkg::KEY_W + TAG_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [EW-1:0] r_mem [CAPACITY];

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pos;
    logic [EW-1:0] r_cur;
    logic [mhpq_pkg::KEY_W-1:0] r_in_key;
    logic [TAG_BITS-1:0] r_in_tag;
    logic [mhpq_pkg::KEY_W-1:0] r_ka;
    logic [TAG_BITS-1:0] r_t1, r_t2;
    logic [mhpq_pkg::KEY_W-1:0] r_mk;
    logic [TAG_BITS-1:0] r_mt;
    logic r_done;

    // Two read ports, registered data, two write ports.
    logic [AW-1:0] rd_a, rd_b;
    logic [EW-1:0] r_qa, r_qb;
    logic we;
    logic [AW-1:0] wa;
    logic [EW-1:0] wd;
    logic we2;
    logic [AW-1:0] wa2;
    logic [EW-1:0] wd2;

    logic [CW:0] lch, rch;
    logic [CW-1:0] up_idx;
    logic lv, rv;
    logic [mhpq_pkg::KEY_W-1:0] kc, kl, kr;
    logic [mhpq_pkg::KEY_W:0] sum_w;
    logic [mhpq_pkg::KEY_W-1:0] sum_s;
    logic [CW-1:0] last;

    assign lch = {r_pos, 1'b1};
    assign rch = {r_pos, 1'b0} + (CW+1)'(2);
    assign up_idx = (r_pos - CW'(1)) >> 1;
    assign last = r_cnt - CW'(1);
    assign kc = r_cur[EW-1:TAG_BITS];
    assign kl = r_qa[EW-1:TAG_BITS];
    assign kr = r_qb[EW-1:TAG_BITS];
    assign lv = lch < {1'b0, r_cnt};
    assign rv = rch < {1'b0, r_cnt};
    // The first removed key is held in r_ka; the second is the root being read.
    assign sum_w = {1'b0, r_ka} + {1'b0, r_qa[EW-1:TAG_BITS]};
    assign sum_s = sum_w[mhpq_pkg::KEY_W] ? '1 : sum_w[mhpq_pkg::KEY_W-1:0];

    always_comb begin
        rd_a = '0;
        rd_b = '0;
        we = 1'b0; wa = '0; wd = '0;
        we2 = 1'b0; wa2 = '0; wd2 = '0;
        unique case (i_cmd.op)
            mhpq_pkg::OP_RD_ROOT: begin
                rd_a = '0;
                rd_b = last[AW-1:0];
            end
            mhpq_pkg::OP_POP_START: begin
                we = 1'b1; wa = '0; wd = r_qb;
            end
            mhpq_pkg::OP_DN_READ: begin
                rd_a = lch[AW-1:0];
                rd_b = rch[AW-1:0];
            end
            mhpq_pkg::OP_DN_STEP: begin
                if (lv && kl < kc && !(rv && kr < kl)) begin
                    we = 1'b1; wa = r_pos[AW-1:0]; wd = r_qa;
                    we2 = 1'b1; wa2 = lch[AW-1:0]; wd2 = r_cur;
                end else if (rv && kr < kc) begin
                    we = 1'b1; wa = r_pos[AW-1:0]; wd = r_qb;
                    we2 = 1'b1; wa2 = rch[AW-1:0]; wd2 = r_cur;
                end
            end
            mhpq_pkg::OP_PUSH_START: begin
                we = 1'b1; wa = r_cnt[AW-1:0];
                wd = i_cmd.use_sum ? {r_ka, r_in_tag} : {r_in_key, r_in_tag};
            end
            mhpq_pkg::OP_UP_READ: rd_a = up_idx[AW-1:0];
            mhpq_pkg::OP_UP_STEP: begin
                if (r_pos != '0 && kl > kc) begin
                    we = 1'b1; wa = r_pos[AW-1:0]; wd = r_qa;
                    we2 = 1'b1; wa2 = up_idx[AW-1:0]; wd2 = r_cur;
                end
            end
            mhpq_pkg::OP_ROOT_READ: rd_a = '0;
            default: ;
        endcase
    end

    // Swaps write both entries in the same cycle; the second write lands
    // through the second write port.
    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[rd_a];
        r_qb <= r_mem[rd_b];
        if (we) r_mem[wa] <= wd;
        if (we2) r_mem[wa2] <= wd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                mhpq_pkg::OP_POP_START: begin
                    r_cnt <= last;
                    r_done <= 1'b0;
                end
                mhpq_pkg::OP_DN_STEP: begin
                    r_done <= !((lv && kl < kc) || (rv && kr < kc));
                end
                mhpq_pkg::OP_PUSH_START: begin
                    r_cnt <= r_cnt + CW'(1);
                    r_done <= 1'b0;
                end
                mhpq_pkg::OP_UP_STEP: r_done <= !(r_pos != '0 && kl > kc);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in_key <= i_key;
            r_in_tag <= i_tag;
        end
        if (i_cmd.clear_tags) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end
        unique case (i_cmd.op)
            mhpq_pkg::OP_POP_START: begin
                if (i_cmd.second_pop) begin
                    r_t2 <= r_qa[TAG_BITS-1:0];
                    r_ka <= sum_s;
                end else begin
                    r_t1 <= r_qa[TAG_BITS-1:0];
                    r_ka <= r_qa[EW-1:TAG_BITS];
                end
                r_cur <= r_qb;
                r_pos <= '0;
            end
            mhpq_pkg::OP_DN_STEP: begin
                if (lv && kl < kc && !(rv && kr < kl)) r_pos <= lch[CW-1:0];
                else if (rv && kr < kc) r_pos <= rch[CW-1:0];
            end
            mhpq_pkg::OP_PUSH_START: begin
                r_pos <= r_cnt;
                r_cur <= i_cmd.use_sum ? {r_ka, r_in_tag} : {r_in_key, r_in_tag};
            end
            mhpq_pkg::OP_UP_STEP: begin
                if (r_pos != '0 && kl > kc) r_pos <= up_idx;
            end
            mhpq_pkg::OP_ROOT_LATCH: begin
                r_mk <= (r_cnt != '0) ? r_qa[EW-1:TAG_BITS] : '0;
                r_mt <= (r_cnt != '0) ? r_qa[TAG_BITS-1:0] : '0;
            end
            default: ;
        endcase
    end

    assign o_stat.done = r_done;
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.lt_two = (r_cnt < CW'(2));
    assign o_stat.full = (r_cnt >= CAP_C);
    assign o_first_tag = r_t1;
    assign o_second_tag = r_t2;
    assign o_min_key = r_mk;
    assign o_min_tag = r_mt;
    assign o_count = r_cnt;
endmodule

FILE: hw/rtl/mhpq_ctrl.sv
module mhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_cmd,
    output logic            o_load,
    output mhpq_pkg::t_cmd  o_cmd,
    input  mhpq_pkg::t_stat i_stat,
    output logic            o_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_POP, S_DRD, S_DST, S_PUSH, S_URD, S_UST, S_RRD, S_RLT, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0] r_op;
    logic r_second;
    logic [1:0] r_status;
    logic r_valid;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_load = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_status = r_status;

    always_comb begin
        o_cmd = '{op: mhpq_pkg::OP_NONE, use_sum: (r_op == mhpq_pkg::CMD_COMBINE),
                  second_pop: r_second, clear_tags: o_load};
        unique case (r_state)
            S_RD:   o_cmd.op = mhpq_pkg::OP_RD_ROOT;
            S_POP:  o_cmd.op = mhpq_pkg::OP_POP_START;
            S_DRD:  o_cmd.op = mhpq_pkg::OP_DN_READ;
            S_DST:  o_cmd.op = mhpq_pkg::OP_DN_STEP;
            S_PUSH: o_cmd.op = mhpq_pkg::OP_PUSH_START;
            S_URD:  o_cmd.op = mhpq_pkg::OP_UP_READ;
            S_UST:  o_cmd.op = mhpq_pkg::OP_UP_STEP;
            S_RRD:  o_cmd.op = mhpq_pkg::OP_ROOT_READ;
            S_RLT:  o_cmd.op = mhpq_pkg::OP_ROOT_LATCH;
            default: o_cmd.op = mhpq_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_op <= mhpq_pkg::CMD_INSERT;
            r_second <= 1'b0;
            r_status <= mhpq_pkg::ST_OK;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_load) begin
                    r_op <= i_cmd;
                    r_second <= 1'b0;
                    r_status <= mhpq_pkg::ST_OK;
                    priority if (i_cmd == mhpq_pkg::CMD_INSERT) begin
                        if (i_stat.full) begin
                            r_status <= mhpq_pkg::ST_FULL;
                            r_state <= S_RRD;
                        end else r_state <= S_PUSH;
                    end else if (i_cmd == mhpq_pkg::CMD_POP) begin
                        if (i_stat.empty) begin
                            r_status <= mhpq_pkg::ST_EMPTY;
                            r_state <= S_RRD;
                        end else r_state <= S_RD;
                    end else if (i_cmd == mhpq_pkg::CMD_COMBINE) begin
                        if (i_stat.lt_two) begin
                            r_status <= mhpq_pkg::ST_EMPTY;
                            r_state <= S_RRD;
                        end else r_state <= S_RD;
                    end else r_state <= S_RRD;
                end
                S_RD:  r_state <= S_POP;
                S_POP: r_state <= S_DRD;
                S_DRD: r_state <= S_DST;
                S_DST: if (i_stat.done) begin
                    if (r_op == mhpq_pkg::CMD_COMBINE && !r_second) begin
                        r_second <= 1'b1;
                        r_state <= S_RD;
                    end else if (r_op == mhpq_pkg::CMD_COMBINE) r_state <= S_PUSH;
                    else r_state <= S_RRD;
                end else r_state <= S_DRD;
                S_PUSH: r_state <= S_URD;
                S_URD:  r_state <= S_UST;
                S_UST:  r_state <= i_stat.done ? S_RRD : S_URD;
                S_RRD:  r_state <= S_RLT;
                S_RLT:  r_state <= S_OUT;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_OUT)) else $error("result out of sequence");
    a_second_combine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_op == mhpq_pkg::CMD_COMBINE)) else $error("second pop outside combine");
`endif
endmodule

FILE: hw/rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue of (key, tag) entries.
// Input channel: i_valid/o_ready with i_cmd, i_key, i_tag. Commands are
// insert, pop minimum, and combine (pop two, push their saturated key sum).
// Output channel: o_valid/i_ready, one result beat per input beat, with
// o_status, removed tags, the new root and the entry count.
// Each beat is processed alone through a two-port heap memory. An insert
// writes the entry at the end and sifts it up; a pop moves the last entry to
// the root and sifts it down; a combine runs two pops and then an insert of
// the sum. A refused or undefined command goes straight to the root report.
// Each sift pass is a read state then a step state, and one extra pass
// confirms where it stops.
// Reset empties the heap at once; memory contents need no clearing.
// A result beat holds until i_ready; no new beat is taken while it waits.
module min_heap_priority_queue #(
    parameter int CAPACITY = 512,
    parameter int TAG_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [31:0]                i_key,
    input  logic [9:0]                 i_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [9:0]                 o_first_tag,
    output logic [9:0]                 o_second_tag,
    output logic [31:0]                o_min_key,
    output logic [9:0]                 o_min_tag,
    output logic [9:0]                 o_count
);
    localparam int CW = $clog2(CAPACITY+1);

    logic load;
    mhpq_pkg::t_cmd cmd;
    mhpq_pkg::t_stat stat;
    logic [TAG_BITS-1:0] t1, t2, mt;
    logic [CW-1:0] cnt;

    mhpq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd,
        .o_load(load), .o_cmd(cmd), .i_stat(stat),
        .o_valid, .i_out_ready(i_ready), .o_status
    );

    mhpq_datapath #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_key,
        .i_tag(TAG_BITS'(i_tag)), .i_cmd(cmd), .o_stat(stat),
        .o_first_tag(t1), .o_second_tag(t2), .o_min_key,
        .o_min_tag(mt), .o_count(cnt)
    );

    assign o_first_tag = 10'(t1);
    assign o_second_tag = 10'(t2);
    assign o_min_tag = 10'(mt);
    assign o_count = 10'(cnt);
endmodule
